// ===== rtl/priority_retry_queue_macros.svh =====
// Assertion macros used by the queue controller.
// Depends on nothing; included inside module bodies.
`ifndef PRIORITY_RETRY_QUEUE_MACROS_SVH
`define PRIORITY_RETRY_QUEUE_MACROS_SVH
// Implication checked every cycle outside reset.
`define PRQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/prq_pkg.sv =====
// Package for the priority retry queue: constants, codes and shared types.
// Used by every module of the block.
package prq_pkg;
    localparam int SLOTS_DEF = 16;
    localparam logic [1:0] K_ADD = 2'd0;
    localparam logic [1:0] K_DISP = 2'd1;
    localparam logic [1:0] K_REPORT = 2'd2;
    localparam logic [1:0] K_CLEAR = 2'd3;
    localparam logic [3:0] ST_ADDED = 4'd0;
    localparam logic [3:0] ST_REPLACED = 4'd1;
    localparam logic [3:0] ST_INVALID = 4'd2;
    localparam logic [3:0] ST_FULL = 4'd3;
    localparam logic [3:0] ST_DISPATCHED = 4'd4;
    localparam logic [3:0] ST_EMPTY = 4'd5;
    localparam logic [3:0] ST_RETRY = 4'd6;
    localparam logic [3:0] ST_DROP_LOW = 4'd7;
    localparam logic [3:0] ST_DROP_EXH = 4'd8;
    localparam logic [3:0] ST_REMOVED = 4'd9;
    localparam logic [3:0] ST_CLEARED = 4'd10;
    localparam logic [1:0] OC_OOM = 2'd1;
    localparam logic [1:0] REG_THR = 2'd0;
    localparam logic [1:0] REG_MAXR = 2'd1;
    localparam logic [1:0] REG_WIN = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  priority_req;
        logic        critical;
        logic [8:0]  length;
        logic [15:0] payload_tag;
        logic [1:0]  outcome;
        logic [31:0] now_ms;
        logic [5:0]  jitter_ms;
    } t_in;

    typedef struct packed {
        logic [3:0]  status;
        logic [3:0]  slot;
        logic [15:0] tag_out;
        logic [7:0]  length_out;
        logic [6:0]  priority_out;
        logic        critical_out;
        logic [2:0]  attempt;
        logic [12:0] backoff_ms;
        logic        kick;
        logic [4:0]  entry_count;
        logic        memory_pressure;
        logic [7:0]  error_count;
    } t_out;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic scan_last;
    } t_stat;
endpackage

// ===== rtl/prq_if.sv =====
// Valid/ready channel interface carrying one queue transaction.
// Depends on nothing.
interface prq_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/prq_ctrl.sv =====
// Controller of the queue: accepts a transaction, sweeps the slots, commits, presents the result.
// Depends on prq_pkg and the macro header.
module prq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  prq_pkg::t_stat i_stat,
    output prq_pkg::t_cmd  o_cmd
);
    import prq_pkg::*;
    `include "priority_retry_queue_macros.svh"

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DONE = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.commit = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    `PRQ_ASSERT_NEXT(a_load_scan, i_clk, i_rst_n, o_cmd.load, r_state == S_SCAN)
    `PRQ_ASSERT_NEXT(a_commit_out, i_clk, i_rst_n, o_cmd.commit, o_out_valid)
    `PRQ_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_out_valid, !o_in_ready)
endmodule

// ===== rtl/prq_dp.sv =====
// Datapath of the queue: slot table, one-slot-per-cycle sweep, retry policy.
// Depends on prq_pkg.
module prq_dp #(
    parameter int SLOTS = prq_pkg::SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  prq_pkg::t_cmd  i_cmd,
    output prq_pkg::t_stat o_stat,
    input  prq_pkg::t_in   i_in,
    input  logic [6:0]    i_thr,
    input  logic [2:0]    i_maxr,
    input  logic [15:0]   i_win,
    output prq_pkg::t_out  o_out
);
    import prq_pkg::*;
    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    logic [SLOTS-1:0] r_valid;
    logic [6:0]  r_pri  [SLOTS];
    logic        r_crit [SLOTS];
    logic [2:0]  r_ret  [SLOTS];
    logic [7:0]  r_len  [SLOTS];
    logic [15:0] r_tag  [SLOTS];
    logic [CW-1:0] r_count;
    logic [7:0]  r_err;
    logic [31:0] r_last;
    logic [IW-1:0] r_disp;

    t_in r_in;
    logic [IW-1:0] r_idx;
    // Sweep results: first free slot, lowest non-critical, highest valid.
    logic r_free_f, r_vic_f, r_best_f;
    logic [IW-1:0] r_free_i, r_vic_i, r_best_i;
    logic [6:0] r_vic_p, r_best_p;
    t_out r_out;

    logic [6:0] pri_c;
    assign pri_c = (r_in.priority_req > 7'd100) ? 7'd100 : r_in.priority_req;
    assign o_stat.scan_last = (r_idx == IW'(SLOTS - 1));
    assign o_out = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in;
            r_idx <= '0;
            r_free_f <= 1'b0;
            r_vic_f <= 1'b0;
            r_best_f <= 1'b0;
            r_free_i <= '0;
            r_vic_i <= '0;
            r_best_i <= '0;
            r_vic_p <= '0;
            r_best_p <= '0;
        end else if (i_cmd.scan_step) begin
            if (!r_valid[r_idx] && !r_free_f) begin
                r_free_f <= 1'b1;
                r_free_i <= r_idx;
            end
            if (!r_crit[r_idx] && (!r_vic_f || r_pri[r_idx] < r_vic_p)) begin
                r_vic_f <= 1'b1;
                r_vic_i <= r_idx;
                r_vic_p <= r_pri[r_idx];
            end
            if (r_valid[r_idx] && (!r_best_f || r_pri[r_idx] > r_best_p)) begin
                r_best_f <= 1'b1;
                r_best_i <= r_idx;
                r_best_p <= r_pri[r_idx];
            end
            if (!o_stat.scan_last) r_idx <= r_idx + 1'b1;
        end
    end

    // Commit logic.
    logic [7:0]  e_new;
    logic [31:0] dt;
    logic        oom_retry;
    logic [2:0]  cur_ret;
    logic [15:0] bo;
    logic [CW-1:0] cnt_rem;
    logic        add_bad;
    logic        add_ok;
    logic [IW-1:0] slot_k;
    t_out        n_out;
    always_comb begin
        dt = r_in.now_ms - r_last;
        e_new = (dt > {16'd0, i_win}) ? 8'd0 : r_err;
        if (e_new != 8'd255) e_new = e_new + 8'd1;
        cur_ret = r_ret[r_disp];
        oom_retry = (r_pri[r_disp] >= i_thr || r_crit[r_disp]) && (cur_ret < i_maxr);
        // The error term alone can reach 25500, so the sum needs 16 bits before the cap.
        bo = 16'(100 << cur_ret);
        if (e_new > 8'd3) bo = bo + 16'(e_new) * 16'd100;
        bo = bo + ((r_in.jitter_ms > 6'd49) ? 16'd49 : 16'(r_in.jitter_ms));
        if (bo > 16'd5000) bo = 16'd5000;
        cnt_rem = (r_count != '0) ? r_count - 1'b1 : r_count;
        add_bad = (r_in.length == 9'd0 || r_in.length > 9'd255);
        add_ok = r_free_f || (r_vic_f && (pri_c > r_vic_p || r_in.critical));
        slot_k = r_free_f ? r_free_i : r_vic_i;
    end

    always_comb begin
        n_out = '0;
        n_out.entry_count = 5'(r_count);
        n_out.error_count = r_err;
        n_out.memory_pressure = (r_err >= 8'd3);
        case (r_in.kind)
            K_ADD: begin
                if (add_bad) begin
                    n_out.status = ST_INVALID;
                end else if (add_ok) begin
                    n_out.status = r_free_f ? ST_ADDED : ST_REPLACED;
                    n_out.slot = 4'(slot_k);
                    if (r_free_f) begin
                        n_out.entry_count = 5'(r_count + 1'b1);
                        n_out.kick = (r_count == '0);
                    end else begin
                        n_out.kick = (r_count == CW'(1));
                    end
                end else begin
                    n_out.status = ST_FULL;
                end
            end
            K_DISP: begin
                if (!r_best_f) n_out.status = ST_EMPTY;
                else begin
                    n_out.status = ST_DISPATCHED;
                    n_out.slot = 4'(r_best_i);
                    n_out.tag_out = r_tag[r_best_i];
                    n_out.length_out = r_len[r_best_i];
                    n_out.priority_out = r_pri[r_best_i];
                    n_out.critical_out = r_crit[r_best_i];
                    n_out.attempt = r_ret[r_best_i];
                end
            end
            K_REPORT: begin
                if (!r_valid[r_disp]) n_out.status = ST_EMPTY;
                else begin
                    n_out.slot = 4'(r_disp);
                    n_out.attempt = cur_ret;
                    if (r_in.outcome == OC_OOM) begin
                        n_out.error_count = e_new;
                        n_out.memory_pressure = (e_new >= 8'd3);
                        if (oom_retry) begin
                            n_out.backoff_ms = bo[12:0];
                            n_out.status = ST_RETRY;
                            n_out.kick = (r_count != '0) && (e_new < 8'd3);
                        end else begin
                            n_out.entry_count = 5'(cnt_rem);
                            n_out.status = (cur_ret >= i_maxr) ? ST_DROP_EXH : ST_DROP_LOW;
                            n_out.kick = (cnt_rem != '0) && (e_new < 8'd3);
                        end
                    end else begin
                        n_out.entry_count = 5'(cnt_rem);
                        n_out.status = ST_REMOVED;
                        n_out.kick = (cnt_rem != '0) && (r_err < 8'd3);
                    end
                end
            end
            default: begin
                n_out.entry_count = '0;
                n_out.status = ST_CLEARED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_err <= '0;
            r_last <= '0;
            r_disp <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_pri[i] <= '0;
                r_crit[i] <= 1'b0;
                r_ret[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            r_out <= n_out;
            case (r_in.kind)
                K_ADD: begin
                    if (!add_bad && add_ok) begin
                        r_tag[slot_k] <= r_in.payload_tag;
                        r_len[slot_k] <= r_in.length[7:0];
                        r_pri[slot_k] <= pri_c;
                        r_crit[slot_k] <= r_in.critical;
                        r_ret[slot_k] <= '0;
                        r_valid[slot_k] <= 1'b1;
                        if (r_free_f) r_count <= r_count + 1'b1;
                    end
                end
                K_DISP: begin
                    if (r_best_f) r_disp <= r_best_i;
                end
                K_REPORT: begin
                    if (r_valid[r_disp]) begin
                        if (r_in.outcome == OC_OOM) begin
                            r_err <= e_new;
                            r_last <= r_in.now_ms;
                            if (oom_retry) begin
                                r_ret[r_disp] <= cur_ret + 3'd1;
                            end else begin
                                r_valid[r_disp] <= 1'b0;
                                r_count <= cnt_rem;
                            end
                        end else begin
                            r_valid[r_disp] <= 1'b0;
                            r_count <= cnt_rem;
                        end
                    end
                end
                default: begin
                    r_valid <= '0;
                    r_count <= '0;
                    for (int i = 0; i < SLOTS; i++) begin
                        r_pri[i] <= '0;
                        r_crit[i] <= 1'b0;
                        r_ret[i] <= '0;
                    end
                end
            endcase
        end
    end
endmodule

// ===== rtl/priority_retry_queue.sv =====
// Priority retry queue: a table of message slots with priority dispatch,
// lowest-priority eviction and a capped exponential retry backoff.
// Transactions arrive on the input channel (kind: add, dispatch, report,
// clear) and each yields exactly one result transaction on the output channel.
// After acceptance the datapath inspects one slot a cycle, then commits the
// result and presents it on the output channel.
// One transaction is in flight at a time; input ready is low from
// acceptance until the result has been taken, and returns in the cycle after.
// A stalled receiver holds the result steady and backs up the input.
// Configuration registers (APB, byte addresses 0, 4, 8): priority
// threshold for retrying out-of-memory failures, maximum retries, and the
// error window in ms. Write them only while idle; reads return the values.
// Synchronous active-low reset empties the table, zeroes the error counter
// and its timestamp, and restores the register defaults 80, 3 and 10000.
// Depends on prq_pkg, prq_if, prq_ctrl and prq_dp.
module priority_retry_queue #(
    parameter int SLOTS = prq_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    prq_if.sink         i_in,
    prq_if.source       o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import prq_pkg::*;

    logic [6:0]  r_thr;
    logic [2:0]  r_maxr;
    logic [15:0] r_win;
    t_cmd  cmd;
    t_stat stat;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 7'd80;
            r_maxr <= 3'd3;
            r_win <= 16'd10000;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_THR:  r_thr <= pwdata[6:0];
                REG_MAXR: r_maxr <= pwdata[2:0];
                REG_WIN:  r_win <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_THR:  prdata = {25'd0, r_thr};
            REG_MAXR: prdata = {29'd0, r_maxr};
            REG_WIN:  prdata = {16'd0, r_win};
            default:  prdata = '0;
        endcase
    end

    prq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .i_stat(stat), .o_cmd(cmd)
    );

    prq_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .o_stat(stat), .i_in(i_in.data),
        .i_thr(r_thr), .i_maxr(r_maxr), .i_win(r_win),
        .o_out(o_out.data)
    );
endmodule

// ===== bench/tb_prq_chan_if.sv =====
`timescale 1ns / 100ps
// Note: the block's own prq_if interface is used for both channels.
// This file holds only a small package of bench-side constants.
// Depends on nothing.
package tb_prq_pkg;
    localparam int QUIET_CYCLES = 40;
endpackage

// ===== bench/tb_priority_retry_queue.sv =====
`timescale 1ns / 100ps
// Self-checking bench for priority_retry_queue: directed and random transactions
// are predicted by a behavioural table model and each result is compared in full.
// Depends on prq_pkg, prq_if, tb_prq_pkg and the block RTL.
module tb_priority_retry_queue;
    import prq_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    prq_if #(.T(t_in)) in_ch ();
    prq_if #(.T(t_out)) out_ch ();

    priority_retry_queue u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #50_000_000;
        $display("status: fail");
        $finish;
    end

    // Shadow of the slot table and registers.
    logic        tbl_valid [16];
    logic [6:0]  tbl_pri [16];
    logic        tbl_crit [16];
    logic [2:0]  tbl_retries [16];
    logic [7:0]  tbl_len [16];
    logic [15:0] tbl_tag [16];
    int unsigned n_occupied, mem_errs, last_err_ms, last_disp;
    int unsigned cfg_thr = 80, cfg_maxr = 3, cfg_win = 10000;

    t_out pending_results[$];
    int   n_fail = 0;
    bit   hold_rx = 1'b0;
    bit   quiet_tx = 1'b0;

    function automatic int unsigned retry_delay(int unsigned r, int unsigned jit);
        int unsigned b;
        b = 100 * (1 << r);
        if (mem_errs > 3) b += mem_errs * 100;
        b += (jit > 49) ? 49 : jit;
        return (b > 5000) ? 5000 : b;
    endfunction

    function automatic t_out predict_queue(t_in t);
        t_out r;
        int unsigned p, idx, low, best;
        bit found, have;
        r = '0;
        p = (t.priority_req > 100) ? 100 : t.priority_req;
        idx = 0;
        case (t.kind)
            K_ADD: begin
                if (t.length == 0 || t.length > 255) begin
                    r.status = ST_INVALID;
                end else begin
                    found = 1'b0;
                    if (n_occupied < 16) begin
                        for (int i = 0; i < 16; i++)
                            if (!found && !tbl_valid[i]) begin idx = i; found = 1'b1; end
                        r.status = ST_ADDED;
                    end else begin
                        low = 255; have = 1'b0;
                        for (int i = 0; i < 16; i++)
                            if (!tbl_crit[i] && tbl_pri[i] < low) begin
                                low = tbl_pri[i]; idx = i; have = 1'b1;
                            end
                        found = have && (p > low || t.critical);
                        r.status = ST_REPLACED;
                    end
                    if (!found) begin
                        r.status = ST_FULL;
                    end else begin
                        tbl_tag[idx] = t.payload_tag;
                        tbl_len[idx] = t.length[7:0];
                        tbl_pri[idx] = p[6:0];
                        tbl_crit[idx] = t.critical;
                        tbl_retries[idx] = 3'd0;
                        if (!tbl_valid[idx]) n_occupied++;
                        tbl_valid[idx] = 1'b1;
                        r.slot = idx[3:0];
                        r.kick = (n_occupied == 1);
                    end
                end
            end
            K_DISP: begin
                have = 1'b0; best = 0;
                for (int i = 0; i < 16; i++)
                    if (tbl_valid[i] && (!have || tbl_pri[i] > best)) begin
                        best = tbl_pri[i]; idx = i; have = 1'b1;
                    end
                if (!have) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.status = ST_DISPATCHED;
                    r.slot = idx[3:0];
                    last_disp = idx;
                    r.tag_out = tbl_tag[idx];
                    r.length_out = tbl_len[idx];
                    r.priority_out = tbl_pri[idx];
                    r.critical_out = tbl_crit[idx];
                    r.attempt = tbl_retries[idx];
                end
            end
            K_REPORT: begin
                if (!tbl_valid[last_disp]) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.slot = last_disp[3:0];
                    r.attempt = tbl_retries[last_disp];
                    if (t.outcome == OC_OOM) begin
                        if (t.now_ms - last_err_ms > cfg_win) mem_errs = 0;
                        if (mem_errs < 255) mem_errs++;
                        last_err_ms = t.now_ms;
                        if ((tbl_pri[last_disp] >= cfg_thr || tbl_crit[last_disp])
                                && tbl_retries[last_disp] < cfg_maxr) begin
                            r.backoff_ms = 13'(retry_delay(tbl_retries[last_disp],
                                                           t.jitter_ms));
                            tbl_retries[last_disp] = 3'(tbl_retries[last_disp] + 1);
                            r.status = ST_RETRY;
                        end else begin
                            r.status = (tbl_retries[last_disp] >= cfg_maxr)
                                ? ST_DROP_EXH : ST_DROP_LOW;
                            tbl_valid[last_disp] = 1'b0;
                            if (n_occupied > 0) n_occupied--;
                        end
                    end else begin
                        tbl_valid[last_disp] = 1'b0;
                        if (n_occupied > 0) n_occupied--;
                        r.status = ST_REMOVED;
                    end
                    r.kick = (n_occupied > 0 && mem_errs < 3);
                end
            end
            default: begin
                for (int i = 0; i < 16; i++) begin
                    tbl_valid[i] = 1'b0; tbl_pri[i] = '0; tbl_crit[i] = 1'b0;
                    tbl_retries[i] = '0; tbl_len[i] = '0; tbl_tag[i] = '0;
                end
                n_occupied = 0;
                r.status = ST_CLEARED;
            end
        endcase
        r.entry_count = n_occupied[4:0];
        r.memory_pressure = (mem_errs >= 3);
        r.error_count = mem_errs[7:0];
        return r;
    endfunction

    // Receiver: random stalls, plus a long hold-off when requested.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_rx) out_ch.ready <= 1'b0;
            else if ($urandom_range(0, 99) < 8) out_ch.ready <= 1'b0;
            else if ($urandom_range(0, 99) < 2) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
                out_ch.ready <= 1'b1;
            end else out_ch.ready <= 1'b1;
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_out got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result %p", $time, got);
                n_fail++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch: expected %p actual %p", $time, want, got);
                    n_fail++;
                end
            end
        end
    end

    // Sends one transaction; the prediction is made at acceptance.
    // Valid always drops between transactions.
    task automatic send_item(t_in t);
        int unsigned gap;
        gap = 1;
        if (!quiet_tx && $urandom_range(0, 99) < 20)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(2, 4);
        repeat (gap) @(posedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data <= t;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(predict_queue(t));
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (tb_prq_pkg::QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, int unsigned val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_THR:  cfg_thr = val & 32'h7f;
            REG_MAXR: cfg_maxr = val & 32'h7;
            default:  cfg_win = val & 32'hffff;
        endcase
    endtask

    function automatic t_in make_item(logic [1:0] k, int unsigned p, bit c, int unsigned len,
                                      int unsigned oc, int unsigned now, int unsigned jit);
        t_in t;
        t = '0;
        t.kind = k; t.priority_req = 7'(p); t.critical = c; t.length = 9'(len);
        t.payload_tag = 16'($urandom); t.outcome = 2'(oc); t.now_ms = now;
        t.jitter_ms = 6'(jit);
        return t;
    endfunction

    function automatic t_in random_item(int unsigned now);
        t_in t;
        int unsigned r;
        t = '0;
        t.priority_req = 7'($urandom);
        t.critical = 1'($urandom);
        t.length = 9'($urandom);
        t.payload_tag = 16'($urandom);
        t.outcome = 2'($urandom);
        t.jitter_ms = 6'($urandom);
        t.now_ms = now;
        r = $urandom_range(0, 99);
        if (r < 40) t.kind = K_ADD;
        else if (r < 70) t.kind = K_DISP;
        else if (r < 97) t.kind = K_REPORT;
        else t.kind = K_CLEAR;
        if ($urandom_range(0, 9) != 0) t.length = 9'($urandom_range(1, 255));
        if ($urandom_range(0, 3) != 0) t.priority_req = 7'($urandom_range(0, 100));
        if ($urandom_range(0, 1)) t.outcome = OC_OOM;
        return t;
    endfunction

    task automatic test_directed;
        send_item(make_item(K_DISP, 0, 0, 1, 0, 0, 0));
        send_item(make_item(K_REPORT, 0, 0, 1, 0, 0, 0));
        send_item(make_item(K_ADD, 5, 0, 0, 0, 0, 0));
        send_item(make_item(K_ADD, 5, 0, 256, 0, 0, 0));
        send_item(make_item(K_ADD, 0, 0, 1, 0, 0, 0));
        send_item(make_item(K_DISP, 0, 0, 1, 0, 0, 0));
        send_item(make_item(K_ADD, 127, 1, 255, 0, 0, 0));
        send_item(make_item(K_ADD, 100, 0, 511, 0, 0, 0));
        send_item(make_item(K_DISP, 0, 0, 1, 0, 0, 0));
        for (int i = 0; i < 4; i++) begin
            send_item(make_item(K_REPORT, 0, 0, 1, OC_OOM, 100 * i, 63));
            send_item(make_item(K_DISP, 0, 0, 1, 0, 0, 0));
        end
        send_item(make_item(K_REPORT, 0, 0, 1, 3, 0, 0));
        send_item(make_item(K_DISP, 0, 0, 1, 0, 0, 0));
        send_item(make_item(K_REPORT, 0, 0, 1, OC_OOM, 32'hffff_ffff, 0));
        send_item(make_item(K_REPORT, 0, 0, 1, 2, 0, 0));
        send_item(make_item(K_CLEAR, 0, 0, 1, 0, 0, 0));
        drain();
    endtask

    // Fills the table, then exercises eviction and full rejection.
    task automatic test_eviction;
        for (int i = 0; i < 16; i++)
            send_item(make_item(K_ADD, $urandom_range(10, 60), i < 3, 10, 0, 0, 0));
        send_item(make_item(K_ADD, 5, 0, 10, 0, 0, 0));
        send_item(make_item(K_ADD, 90, 0, 10, 0, 0, 0));
        send_item(make_item(K_ADD, 0, 1, 10, 0, 0, 0));
        send_item(make_item(K_CLEAR, 0, 0, 1, 0, 0, 0));
        for (int i = 0; i < 17; i++)
            send_item(make_item(K_ADD, 50, 1, 10, 0, 0, 0));
        send_item(make_item(K_CLEAR, 0, 0, 1, 0, 0, 0));
        drain();
    endtask

    task automatic test_random(int unsigned n);
        int unsigned now;
        now = $urandom;
        for (int i = 0; i < n; i++) begin
            now += $urandom_range(0, 3000);
            send_item(random_item(now));
        end
        drain();
    endtask

    // Receiver holds off while the sender keeps offering transactions.
    task automatic test_backpressure;
        fork
            begin
                hold_rx = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            begin
                quiet_tx = 1'b1;
                for (int i = 0; i < 10; i++)
                    send_item(make_item(K_ADD, $urandom_range(0, 100), 0, 7, 0, 0, 0));
                quiet_tx = 1'b0;
            end
        join
        drain();
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        n_occupied = 0; mem_errs = 0; last_err_ms = 0; last_disp = 0;
        for (int i = 0; i < 16; i++) begin
            tbl_valid[i] = 1'b0; tbl_pri[i] = '0; tbl_crit[i] = 1'b0;
            tbl_retries[i] = '0; tbl_len[i] = '0; tbl_tag[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_eviction();
        test_random(300);
        apb_write(REG_THR, 0);
        apb_write(REG_MAXR, 7);
        apb_write(REG_WIN, 65535);
        test_random(250);
        test_backpressure();
        apb_write(REG_THR, 100);
        apb_write(REG_MAXR, 0);
        apb_write(REG_WIN, 0);
        test_random(200);
        apb_write(REG_THR, 50);
        apb_write(REG_MAXR, 5);
        apb_write(REG_WIN, 2000);
        test_random(200);
        if (n_fail == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

// ===== priority_retry_queue.f =====
+incdir+rtl
rtl/prq_pkg.sv
rtl/prq_if.sv
rtl/prq_ctrl.sv
rtl/prq_dp.sv
rtl/priority_retry_queue.sv
bench/tb_prq_chan_if.sv
bench/tb_priority_retry_queue.sv
